// ===== hw/rtl/gdbp_pkg.sv =====
package gdbp_pkg;

  localparam int CW_W   = 23;
  localparam int SYN_W  = 11;
  localparam int DATA_W = 12;
  localparam int ROM_D  = 1 << SYN_W;
  localparam logic [SYN_W:0] GOLAY_GEN = 12'hC75;

  typedef logic [SYN_W-1:0]  syn_tab_t [CW_W];
  typedef logic [DATA_W-1:0] err_rom_t [ROM_D];

  // x^i mod g for every codeword bit
  function automatic syn_tab_t build_col_syn();
    syn_tab_t       t;
    logic [SYN_W:0] r;
    r = {{SYN_W{1'b0}}, 1'b1};
    for (int i = 0; i < CW_W; i++) begin
      t[i] = r[SYN_W-1:0];
      r = {r[SYN_W-1:0], 1'b0};
      if (r[SYN_W]) begin
        r = r ^ GOLAY_GEN;
      end
    end
    return t;
  endfunction

  localparam syn_tab_t COL_SYN = build_col_syn();

  // syndrome -> data-bit part of the weight <= 3 error pattern
  function automatic err_rom_t build_err_rom();
    err_rom_t        t;
    logic [CW_W-1:0] e;
    for (int n = 0; n < ROM_D; n++) begin
      t[n] = '0;
    end
    for (int i = 0; i < CW_W; i++) begin
      for (int j = i + 1; j < CW_W; j++) begin
        for (int k = j + 1; k < CW_W; k++) begin
          e = '0;
          e[i] = 1'b1;
          e[j] = 1'b1;
          e[k] = 1'b1;
          t[COL_SYN[i] ^ COL_SYN[j] ^ COL_SYN[k]] = e[CW_W-1:CW_W-DATA_W];
        end
      end
    end
    for (int i = 0; i < CW_W; i++) begin
      for (int j = i + 1; j < CW_W; j++) begin
        e = '0;
        e[i] = 1'b1;
        e[j] = 1'b1;
        t[COL_SYN[i] ^ COL_SYN[j]] = e[CW_W-1:CW_W-DATA_W];
      end
    end
    for (int i = 0; i < CW_W; i++) begin
      e = '0;
      e[i] = 1'b1;
      t[COL_SYN[i]] = e[CW_W-1:CW_W-DATA_W];
    end
    t[0] = '0;
    return t;
  endfunction

  localparam err_rom_t ERR_ROM = build_err_rom();

endpackage

// ===== hw/rtl/golay_23_12_decoder_byte_packer.sv =====
// Golay (23,12) decoder with 12-bit to byte packing. Each request on the code
// channel is one 24-bit group (bits 23..1 codeword, bit 0 pad); the corrected
// 12 data bits of two groups leave as three bytes, one for the first group and
// two for the second, with last set on the final byte of each group. Up to
// three errors per codeword are corrected silently. Three register stages:
// input/syndrome, error lookup in a 2048 x 12 constant table with registered
// read, and a two-byte output buffer. A group is taken every cycle while the
// output keeps up; the byte-wide output sets the sustained rate, and the lookup
// stage waits while the third byte of a pair is sent. The first byte of a group
// passes through the input and lookup registers before it is presented.
module golay_23_12_decoder_byte_packer (
  input  logic        clk,
  input  logic        rst,
  input  logic        code_valid,
  output logic        code_stall,
  input  logic [23:0] code_group,
  output logic        byte_valid,
  input  logic        byte_stall,
  output logic [7:0]  out_byte,
  output logic        last
);
  import gdbp_pkg::*;

  logic              a_valid;
  logic [DATA_W-1:0] a_data;
  logic [SYN_W-1:0]  a_syn;
  logic              b_valid;
  logic [DATA_W-1:0] b_data;
  logic [DATA_W-1:0] b_err;
  logic              pend_valid;
  logic [7:0]        pend_byte;
  logic              second_of_pair;
  logic [3:0]        held_nibble;

  logic [SYN_W-1:0]  syn;
  logic [DATA_W-1:0] dec;
  logic              out_free;
  logic              take_b;
  logic              b_free;
  logic              accept;

  always_comb begin
    syn = '0;
    for (int i = 0; i < CW_W; i++) begin
      if (code_group[i+1]) begin
        syn = syn ^ COL_SYN[i];
      end
    end
  end

  assign out_free   = !byte_valid || (!byte_stall && !pend_valid);
  assign take_b     = b_valid && out_free;
  assign b_free     = !b_valid || take_b;
  assign code_stall = a_valid && !b_free;
  assign accept     = code_valid && !code_stall;
  assign dec        = b_data ^ b_err;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (!code_stall) begin
      a_valid <= code_valid;
    end
    if (accept) begin
      a_data <= code_group[23:24-DATA_W];
      a_syn  <= syn;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (b_free) begin
      b_valid <= a_valid;
    end
    if (a_valid && b_free) begin
      b_data <= a_data;
      b_err  <= ERR_ROM[a_syn];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid     <= 1'b0;
      pend_valid     <= 1'b0;
      second_of_pair <= 1'b0;
      held_nibble    <= '0;
    end else if (take_b) begin
      byte_valid <= 1'b1;
      if (!second_of_pair) begin
        out_byte       <= dec[11:4];
        last           <= 1'b1;
        held_nibble    <= dec[3:0];
        second_of_pair <= 1'b1;
      end else begin
        out_byte       <= {held_nibble, dec[11:8]};
        last           <= 1'b0;
        pend_valid     <= 1'b1;
        pend_byte      <= dec[7:0];
        second_of_pair <= 1'b0;
      end
    end else if (byte_valid && !byte_stall) begin
      if (pend_valid) begin
        out_byte   <= pend_byte;
        last       <= 1'b1;
        pend_valid <= 1'b0;
      end else begin
        byte_valid <= 1'b0;
      end
    end
  end

  a_pend_has_head: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> byte_valid)
    else $error("pending byte without head byte");

  a_last_follows: assert property (@(posedge clk) disable iff (rst)
    (byte_valid && !byte_stall && !last) |=> (byte_valid && last))
    else $error("second byte of group missing");

  a_pair_toggle: assert property (@(posedge clk) disable iff (rst)
    take_b |=> (second_of_pair != $past(second_of_pair)))
    else $error("pair phase did not advance");

endmodule

// ===== verif/golay_23_12_decoder_byte_packer_checker.sv =====
module golay_23_12_decoder_byte_packer_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        code_valid,
  input  logic        code_stall,
  input  logic [23:0] code_group,
  input  logic        byte_valid,
  input  logic        byte_stall,
  input  logic [7:0]  out_byte,
  input  logic        last,
  output int          fails,
  output int          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [11:0] GEN_POLY = 12'hC75;

  typedef struct packed {
    logic [7:0] data;
    logic       fin;
  } byte_req_t;

  byte_req_t   expected_bytes [$];
  logic [22:0] fix_pattern [2048];
  logic        pair_second;
  logic [3:0]  nibble_hold;

  function automatic logic [10:0] syndrome(input logic [22:0] cw);
    logic [22:0] r;
    r = cw;
    for (int b = 22; b >= 11; b--) begin
      if (r[b]) begin
        r = r ^ (23'(GEN_POLY) << (b - 11));
      end
    end
    return r[10:0];
  endfunction

  // nearest codeword: every syndrome maps to a pattern of weight <= 3
  initial begin : build_fix_table
    logic [10:0] cs [23];
    for (int i = 0; i < 23; i++) begin
      cs[i] = syndrome(23'(1) << i);
    end
    for (int n = 0; n < 2048; n++) begin
      fix_pattern[n] = '0;
    end
    for (int i = 0; i < 23; i++) begin
      for (int j = i + 1; j < 23; j++) begin
        for (int k = j + 1; k < 23; k++) begin
          fix_pattern[cs[i] ^ cs[j] ^ cs[k]] = (23'(1) << i) | (23'(1) << j) | (23'(1) << k);
        end
      end
    end
    for (int i = 0; i < 23; i++) begin
      for (int j = i + 1; j < 23; j++) begin
        fix_pattern[cs[i] ^ cs[j]] = (23'(1) << i) | (23'(1) << j);
      end
    end
    for (int i = 0; i < 23; i++) begin
      fix_pattern[cs[i]] = 23'(1) << i;
    end
    fix_pattern[0] = '0;
  end

  function automatic logic [11:0] corrected_data(input logic [23:0] g);
    logic [22:0] cw;
    cw = g[23:1];
    cw = cw ^ fix_pattern[syndrome(cw)];
    return cw[22:11];
  endfunction

  always @(posedge clk) begin : monitor
    byte_req_t   want;
    logic [11:0] d;
    if (rst) begin
      pair_second = 1'b0;
      nibble_hold = '0;
      expected_bytes.delete();
    end else begin
      if (code_valid && !code_stall) begin
        d = corrected_data(code_group);
        if (!pair_second) begin
          want.data = d[11:4];
          want.fin  = 1'b1;
          expected_bytes = {expected_bytes, want};
          nibble_hold = d[3:0];
          pair_second = 1'b1;
        end else begin
          want.data = {nibble_hold, d[11:8]};
          want.fin  = 1'b0;
          expected_bytes = {expected_bytes, want};
          want.data = d[7:0];
          want.fin  = 1'b1;
          expected_bytes = {expected_bytes, want};
          pair_second = 1'b0;
        end
      end
      if (byte_valid && !byte_stall) begin
        if (expected_bytes.size() == 0) begin
          fails++;
          $display("%0t: unexpected byte request: out_byte %h last %b", $time, out_byte, last);
        end else begin
          want = expected_bytes.pop_front();
          if (out_byte !== want.data) begin
            fails++;
            $display("%0t: out_byte mismatch: expected %h actual %h", $time, want.data, out_byte);
          end
          if (last !== want.fin) begin
            fails++;
            $display("%0t: last mismatch: expected %b actual %b", $time, want.fin, last);
          end
        end
      end
    end
    outstanding = expected_bytes.size();
  end

endmodule

// ===== verif/golay_23_12_decoder_byte_packer_test.sv =====
module golay_23_12_decoder_byte_packer_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [11:0] GEN_POLY = 12'hC75;

  logic        clk;
  logic        rst;
  logic        code_valid;
  logic        code_stall;
  logic [23:0] code_group;
  logic        byte_valid;
  logic        byte_stall;
  logic [7:0]  out_byte;
  logic        last;
  int          fails;
  int          outstanding;
  bit          steady;
  int          stall_hold;

  golay_23_12_decoder_byte_packer dut (
    .clk        (clk),
    .rst        (rst),
    .code_valid (code_valid),
    .code_stall (code_stall),
    .code_group (code_group),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .out_byte   (out_byte),
    .last       (last)
  );

  golay_23_12_decoder_byte_packer_checker scorer (
    .clk         (clk),
    .rst         (rst),
    .code_valid  (code_valid),
    .code_stall  (code_stall),
    .code_group  (code_group),
    .byte_valid  (byte_valid),
    .byte_stall  (byte_stall),
    .out_byte    (out_byte),
    .last        (last),
    .fails       (fails),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("golay_23_12_decoder_byte_packer_test failed");
    $finish;
  end

  // systematic encode: data in the top 12 bits, remainder below
  function automatic logic [22:0] encode(input logic [11:0] d);
    logic [22:0] r;
    r = {d, 11'b0};
    for (int b = 22; b >= 11; b--) begin
      if (r[b]) begin
        r = r ^ (23'(GEN_POLY) << (b - 11));
      end
    end
    return {d, r[10:0]};
  endfunction

  function automatic logic [22:0] error_mask(input int weight);
    logic [22:0] m;
    m = '0;
    while ($countones(m) < weight) begin
      m[$urandom_range(0, 22)] = 1'b1;
    end
    return m;
  endfunction

  // mostly short, a few long
  function automatic int idle_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 70) begin
      return 0;
    end else if (p < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  task automatic send(input logic [23:0] g);
    int gap;
    @(negedge clk);
    code_valid <= 1'b1;
    code_group <= g;
    do @(posedge clk); while (code_stall);
    gap = steady ? 0 : idle_len();
    repeat (gap) begin
      @(negedge clk);
      code_valid <= 1'b0;
    end
  endtask

  initial begin
    byte_stall = 1'b0;
    stall_hold = 0;
    forever begin
      @(negedge clk);
      if (stall_hold > 0) begin
        stall_hold--;
        byte_stall <= 1'b1;
      end else begin
        stall_hold = steady ? 0 : idle_len();
        byte_stall <= (stall_hold > 0);
        if (stall_hold > 0) begin
          stall_hold--;
        end
      end
    end
  end

  initial begin
    int          sel;
    logic [23:0] g;
    rst        = 1'b1;
    code_valid = 1'b0;
    code_group = '0;
    steady     = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    send(24'h000000);
    send(24'hFFFFFF);
    send({encode(12'hFFF), 1'b0});
    send({encode(12'h000) ^ 23'h000001, 1'b1});
    send({encode(12'hFFF) ^ (23'(1) << 22), 1'b0});
    send({encode(12'h800) ^ ((23'(1) << 22) | 23'(1)), 1'b1});
    send({encode(12'h001) ^ ((23'(1) << 11) | (23'(1) << 10) | (23'(1) << 21)), 1'b0});
    send({encode(12'hA5A) ^ error_mask(4), 1'b1});
    send({encode(12'h5A5) ^ error_mask(7), 1'b0});
    send({encode(12'h123), 1'b1});
    send({encode(12'h0F0) ^ error_mask(23), 1'b1});
    send({encode(12'hF0F) ^ error_mask(3), 1'b0});
    for (int w = 0; w <= 6; w++) begin
      send({encode(12'($urandom)) ^ error_mask(w), 1'($urandom)});
    end

    @(negedge clk);
    code_valid <= 1'b0;
    wait (outstanding == 0);

    for (int n = 0; n < 850; n++) begin
      steady = (n >= 300 && n < 400);
      if (n == 600) begin
        @(negedge clk);
        code_valid <= 1'b0;
        wait (outstanding == 0);
      end
      sel = $urandom_range(0, 99);
      if (sel < 75) begin
        g = {encode(12'($urandom)) ^ error_mask($urandom_range(0, 3)), 1'($urandom)};
      end else if (sel < 85) begin
        g = {encode(12'($urandom)) ^ error_mask($urandom_range(4, 8)), 1'($urandom)};
      end else begin
        g = 24'($urandom);
      end
      send(g);
    end
    steady = 1'b0;

    @(negedge clk);
    code_valid <= 1'b0;
    wait (outstanding == 0);
    repeat (10) @(posedge clk);
    if (fails == 0) begin
      $display("golay_23_12_decoder_byte_packer_test passed");
    end else begin
      $display("golay_23_12_decoder_byte_packer_test failed");
    end
    $finish;
  end

endmodule
